// ===== rtl/jsrd_pkg.sv =====
// Shared types, constants and helpers of the joystick serial record decoder.
`default_nettype none

package jsrd_pkg;

  // Axis scale and the clamp limit, kept inside the 7-bit signed output range
  localparam int FULL_SCALE = 34;
  localparam int AXIS_LIM   = (FULL_SCALE > 63) ? 63 : FULL_SCALE;

  // Tick counter
  localparam int          CNT_W         = 24;
  localparam logic [23:0] CNT_MAX       = 24'hFF_FFFF;
  localparam logic [23:0] TIMEOUT_RESET = 24'd200;

  // Greeting characters dropped after reset
  localparam logic [1:0] GREETING_LEN = 2'd2;

  // Character bits
  localparam int HDR_MARK_BIT = 6;
  localparam int BLUE_BIT     = 4;
  localparam int RED_BIT      = 5;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Report kinds
  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_AXIS   = 1'b1;

  // Output queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  // Held axes and buttons, carried by every report
  typedef struct packed {
    logic              red;
    logic              yellow;
    logic              blue;
    logic signed [6:0] y;
    logic signed [6:0] x;
  } rec_t;

  // Reports caused by one input item (zero, one or two, all with the same record)
  typedef struct packed {
    logic [1:0] num;
    logic       first_kind;
    rec_t       rec;
  } report_t;

  // One queued output transaction
  typedef struct packed {
    logic kind;
    logic last;
    rec_t rec;
  } out_t;

  // Clamp a 9-bit signed value to +/- AXIS_LIM
  function automatic logic signed [6:0] clamp_axis(input logic signed [8:0] v);
    logic signed [8:0] lim;
    lim = 9'(AXIS_LIM);
    if (v > lim) begin
      return lim[6:0];
    end else if (v < -lim) begin
      return 7'(-lim);
    end
    return v[6:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jsrd_decode.sv =====
// Record decoder: parser state, held values, tick counter and report generation.
`default_nettype none

module jsrd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              cmd_i,
  input  wire logic [6:0]        byte_i,
  input  wire logic [23:0]       timeout_i,
  output jsrd_pkg::report_t      report_o
);

  typedef enum logic [1:0] {
    POS_SYNC,
    POS_X,
    POS_Y,
    POS_TAIL
  } pos_e;

  pos_e              pos_q, pos_d;
  logic [1:0]        greet_q, greet_d;
  logic [6:0]        hdr_q, hdr_d;
  logic [6:0]        xb_q, xb_d;
  jsrd_pkg::rec_t    rec_q, rec_d;
  logic [23:0]       cnt_q, cnt_d;

  logic [23:0]       cnt_inc;
  logic signed [7:0] raw_x, raw_y;
  logic signed [6:0] new_x, new_y;
  logic              is_hdr;

  // Raw axes: header bits fill the top of each 8-bit value (bit 6 is or-ed)
  assign raw_x   = {hdr_q[1], hdr_q[0] | xb_q[6], xb_q[5:0]};
  assign raw_y   = {hdr_q[3], hdr_q[2] | byte_i[6], byte_i[5:0]};
  assign new_x   = jsrd_pkg::clamp_axis(-{raw_x[7], raw_x});
  assign new_y   = jsrd_pkg::clamp_axis({raw_y[7], raw_y});
  assign is_hdr  = byte_i[jsrd_pkg::HDR_MARK_BIT];
  assign cnt_inc = (cnt_q == jsrd_pkg::CNT_MAX) ? cnt_q : cnt_q + 24'd1;

  // Next state and reports
  always_comb begin
    logic btn_chg;
    logic axis_chg;
    pos_d    = pos_q;
    greet_d  = greet_q;
    hdr_d    = hdr_q;
    xb_d     = xb_q;
    rec_d    = rec_q;
    cnt_d    = cnt_q;
    btn_chg  = 1'b0;
    axis_chg = 1'b0;
    report_o = '0;
    if (en_i) begin
      if (cmd_i == jsrd_pkg::CMD_TICK) begin
        cnt_d = cnt_inc;
        if (cnt_inc > timeout_i && (rec_q.x != 7'sd0 || rec_q.y != 7'sd0)) begin
          rec_d.x             = '0;
          rec_d.y             = '0;
          cnt_d               = '0;
          report_o.num        = 2'd1;
          report_o.first_kind = jsrd_pkg::KIND_AXIS;
        end
      end else if (greet_q != 2'd0) begin
        greet_d = greet_q - 2'd1;
      end else begin
        unique case (pos_q)
          POS_SYNC: begin
            if (is_hdr) begin
              hdr_d = byte_i;
              pos_d = POS_X;
            end
          end
          POS_X: begin
            xb_d  = byte_i;
            pos_d = POS_Y;
          end
          POS_Y: begin
            rec_d.x    = new_x;
            rec_d.y    = new_y;
            rec_d.blue = hdr_q[jsrd_pkg::BLUE_BIT];
            rec_d.red  = hdr_q[jsrd_pkg::RED_BIT];
            btn_chg    = (rec_d.blue != rec_q.blue) || (rec_d.red != rec_q.red);
            axis_chg   = (new_x != rec_q.x) || (new_y != rec_q.y);
            if (axis_chg) begin
              cnt_d = '0;
            end
            report_o.num        = {1'b0, btn_chg} + {1'b0, axis_chg};
            report_o.first_kind = btn_chg ? jsrd_pkg::KIND_BUTTON : jsrd_pkg::KIND_AXIS;
            pos_d               = POS_TAIL;
          end
          POS_TAIL: begin
            if (is_hdr) begin
              hdr_d = byte_i;
              pos_d = POS_X;
            end else begin
              rec_d.yellow = (byte_i != 7'd0);
              if (rec_d.yellow != rec_q.yellow) begin
                report_o.num        = 2'd1;
                report_o.first_kind = jsrd_pkg::KIND_BUTTON;
              end
              pos_d = POS_SYNC;
            end
          end
          default: pos_d = POS_SYNC;
        endcase
      end
    end
    report_o.rec = rec_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_SYNC;
      greet_q <= jsrd_pkg::GREETING_LEN;
      hdr_q   <= '0;
      xb_q    <= '0;
      rec_q   <= '0;
      cnt_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      greet_q <= greet_d;
      hdr_q   <= hdr_d;
      xb_q    <= xb_d;
      rec_q   <= rec_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsrd_out_q.sv =====
// Output queue: takes up to two reports per cycle, hands out one per transaction.
`default_nettype none

module jsrd_out_q (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire jsrd_pkg::report_t             report_i,
  input  wire logic                          pop_i,
  output jsrd_pkg::out_t                     head_o,
  output logic                               valid_o,
  output logic [jsrd_pkg::QLVL_W-1:0]        level_o
);

  localparam int QPTR_W = jsrd_pkg::QPTR_W;
  localparam int QLVL_W = jsrd_pkg::QLVL_W;

  jsrd_pkg::out_t                    mem_q [jsrd_pkg::QDEPTH];
  logic [jsrd_pkg::QPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [jsrd_pkg::QLVL_W-1:0]       lvl_q, lvl_d;
  logic [1:0]                        n_push;
  logic                              do_pop;
  jsrd_pkg::out_t                    ent0, ent1;

  assign n_push = push_i ? report_i.num : 2'd0;
  assign do_pop = pop_i && (lvl_q != '0);

  // Entries for this cycle's reports
  always_comb begin
    ent0.kind = report_i.first_kind;
    ent0.last = (report_i.num == 2'd1);
    ent0.rec  = report_i.rec;
    ent1.kind = jsrd_pkg::KIND_AXIS;
    ent1.last = 1'b1;
    ent1.rec  = report_i.rec;
  end

  // Pointer and level update
  always_comb begin
    wr_d  = wr_q + QPTR_W'(n_push);
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    lvl_d = lvl_q + QLVL_W'(n_push) - QLVL_W'(do_pop);
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= ent0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + QPTR_W'(1)] <= ent1;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (lvl_q != '0);
  assign level_o = lvl_q;

endmodule

`default_nettype wire

// ===== rtl/joystick_serial_record_decoder.sv =====
// Top level of the joystick serial record decoder: input register, decoder, output queue.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: command, tdata: rx_byte
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: report_kind, tdata: axes, buttons
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i: timeout_ticks
//
// One item per cycle enters the input register; the decoder handles it from there
// once the 4-entry output queue has room for two reports, so the input side
// runs at one item per cycle while the output side keeps up (one report per cycle).
// An item passes the input register, then the decoder; its reports are registered in the output queue.
// Reset (rst_ni, async low) clears the parser, held values, counter and queue;
// timeout_ticks resets to 200. Configuration is always ready.
`default_nettype none

module joystick_serial_record_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] rx_byte, [7] zero
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [6:0] axis_x, [13:7] axis_y, [14] button_blue,
                                           // [15] button_yellow, [16] button_red, [23:17] zero
  output logic             m_axis_tuser,   // [0] report_kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [23:0] cfg_data_i
);

  logic                              in_valid_q;
  logic                              in_cmd_q;
  logic [6:0]                        in_byte_q;
  logic [23:0]                       timeout_q;
  logic                              proc;
  jsrd_pkg::report_t                 report;
  jsrd_pkg::out_t                    head;
  logic                              q_valid;
  logic [jsrd_pkg::QLVL_W-1:0]       q_level;

  // Process when the queue can take two reports
  assign proc          = in_valid_q && (q_level <= jsrd_pkg::QLVL_W'(jsrd_pkg::QDEPTH - 2));
  assign s_axis_tready = !in_valid_q || proc;
  assign cfg_ready_o   = 1'b1;

  // Input register and timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      timeout_q  <= jsrd_pkg::TIMEOUT_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[6:0];
    end
  end

  jsrd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (proc),
    .cmd_i     (in_cmd_q),
    .byte_i    (in_byte_q),
    .timeout_i (timeout_q),
    .report_o  (report)
  );

  jsrd_out_q u_out_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (proc),
    .report_i (report),
    .pop_i    (m_axis_tready),
    .head_o   (head),
    .valid_o  (q_valid),
    .level_o  (q_level)
  );

  // Output transaction
  assign m_axis_tvalid = q_valid;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {7'd0, head.rec.red, head.rec.yellow, head.rec.blue,
                          head.rec.y, head.rec.x};

  // Checks
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= jsrd_pkg::QLVL_W'(jsrd_pkg::QDEPTH))
    else $error("output queue level above depth");

  a_report_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && report.num != 2'd0) |=> m_axis_tvalid)
    else $error("report produced but no output transaction offered");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_cmd_q == jsrd_pkg::CMD_TICK && report.num != 2'd0)
      |-> (report.rec.x == 7'sd0 && report.rec.y == 7'sd0 && report.num == 2'd1))
    else $error("timeout report with non-zero axes");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> timeout_q == $past(cfg_data_i))
    else $error("timeout register not written");

endmodule

`default_nettype wire

// ===== verif/joystick_report_checker.sv =====
// Checker for the joystick serial record decoder: predicts and compares the report stream.
`default_nettype none

module joystick_report_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [6:0] rx_byte, [7] zero
  input  wire logic        s_axis_tuser,   // [0] command
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,   // [6:0] axis_x, [13:7] axis_y, [14] blue,
                                           // [15] yellow, [16] red, [23:17] zero
  input  wire logic        m_axis_tuser,   // [0] report_kind
  input  wire logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [23:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               items_o,
  output int               reports_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  // Where the parser stands inside a record
  typedef enum logic [1:0] {
    WAIT_HEADER,
    GOT_HEADER,
    GOT_X,
    AFTER_RECORD
  } rec_pos_e;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic signed [6:0] x;
    logic signed [6:0] y;
    logic              blue;
    logic              yellow;
    logic              red;
  } joy_report_t;

  joy_report_t expected_reports[$];

  // Predicted decoder state
  logic [23:0]       timeout_ticks;
  logic [1:0]        greeting_left;
  rec_pos_e          byte_pos;
  logic [6:0]        header;
  logic [6:0]        x_byte;
  logic signed [6:0] held_x;
  logic signed [6:0] held_y;
  logic              held_blue;
  logic              held_yellow;
  logic              held_red;
  logic [23:0]       ticks;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t ns: MISMATCH %s", $time, msg);
    end
    fail_count_o++;
  endtask

  // Saturate an axis to the output limit
  function automatic logic signed [6:0] limit_axis(input int v);
    if (v > jsrd_pkg::AXIS_LIM) begin
      return 7'(jsrd_pkg::AXIS_LIM);
    end
    if (v < -jsrd_pkg::AXIS_LIM) begin
      return 7'(-jsrd_pkg::AXIS_LIM);
    end
    return 7'(v);
  endfunction

  // Two header bits land on bits 7:6 of the raw axis, OR-ed over the byte
  function automatic int raw_axis(input logic [1:0] hi, input logic [6:0] lo);
    logic [7:0] raw;
    raw = {1'b0, lo} | {hi, 6'b0};
    return int'($signed(raw));
  endfunction

  function automatic joy_report_t snapshot(input logic kind);
    joy_report_t r;
    r.kind   = kind;
    r.last   = 1'b0;
    r.x      = held_x;
    r.y      = held_y;
    r.blue   = held_blue;
    r.yellow = held_yellow;
    r.red    = held_red;
    return r;
  endfunction

  // Work out the reports caused by one input transaction
  task automatic decode_item(input logic cmd, input logic [6:0] b);
    joy_report_t       made[$];
    logic signed [6:0] nx;
    logic signed [6:0] ny;
    logic              axis_moved;
    if (cmd == jsrd_pkg::CMD_TICK) begin
      if (ticks != jsrd_pkg::CNT_MAX) begin
        ticks++;
      end
      if (ticks > timeout_ticks && (held_x != 0 || held_y != 0)) begin
        held_x = '0;
        held_y = '0;
        ticks  = '0;
        made.push_back(snapshot(jsrd_pkg::KIND_AXIS));
      end
    end else if (greeting_left != 0) begin
      greeting_left--;
    end else begin
      case (byte_pos)
        WAIT_HEADER: begin
          if (b[jsrd_pkg::HDR_MARK_BIT]) begin
            header   = b;
            byte_pos = GOT_HEADER;
          end
        end
        GOT_HEADER: begin
          x_byte   = b;
          byte_pos = GOT_X;
        end
        GOT_X: begin
          nx = limit_axis(-raw_axis(header[1:0], x_byte));
          ny = limit_axis(raw_axis(header[3:2], b));
          axis_moved = (nx != held_x) || (ny != held_y);
          held_x = nx;
          held_y = ny;
          if (header[jsrd_pkg::BLUE_BIT] != held_blue ||
              header[jsrd_pkg::RED_BIT] != held_red) begin
            held_blue = header[jsrd_pkg::BLUE_BIT];
            held_red  = header[jsrd_pkg::RED_BIT];
            made.push_back(snapshot(jsrd_pkg::KIND_BUTTON));
          end
          if (axis_moved) begin
            ticks = '0;
            made.push_back(snapshot(jsrd_pkg::KIND_AXIS));
          end
          byte_pos = AFTER_RECORD;
        end
        default: begin
          if (b[jsrd_pkg::HDR_MARK_BIT]) begin
            header   = b;
            byte_pos = GOT_HEADER;
          end else begin
            // optional trailing byte: any nonzero value means yellow pressed
            if ((b != 0) != held_yellow) begin
              held_yellow = (b != 0);
              made.push_back(snapshot(jsrd_pkg::KIND_BUTTON));
            end
            byte_pos = WAIT_HEADER;
          end
        end
      endcase
    end
    if (made.size() > 0) begin
      made[made.size() - 1].last = 1'b1;
    end
    foreach (made[i]) begin
      expected_reports.push_back(made[i]);
    end
  endtask

  task automatic compare_field(input string field, input logic [6:0] got,
                               input logic [6:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("report %0d %s: got %0d expected %0d", reports_o, field,
                                $signed(got), $signed(want)));
    end
  endtask

  // Compare one output transaction with the oldest expected report
  task automatic check_report();
    joy_report_t want;
    reports_o++;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("report %0d unexpected: tdata=%h tuser=%b tlast=%b",
                                reports_o, m_axis_tdata, m_axis_tuser, m_axis_tlast));
      return;
    end
    want = expected_reports.pop_front();
    compare_field("report_kind", 7'(m_axis_tuser), 7'(want.kind));
    compare_field("last", 7'(m_axis_tlast), 7'(want.last));
    compare_field("axis_x", m_axis_tdata[6:0], want.x);
    compare_field("axis_y", m_axis_tdata[13:7], want.y);
    compare_field("button_blue", 7'(m_axis_tdata[14]), 7'(want.blue));
    compare_field("button_yellow", 7'(m_axis_tdata[15]), 7'(want.yellow));
    compare_field("button_red", 7'(m_axis_tdata[16]), 7'(want.red));
    compare_field("tdata padding", m_axis_tdata[23:17], 7'b0);
  endtask

  // Output side is checked before the input side: a report never comes from
  // the transaction accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_reports.delete();
      timeout_ticks = jsrd_pkg::TIMEOUT_RESET;
      greeting_left = jsrd_pkg::GREETING_LEN;
      byte_pos      = WAIT_HEADER;
      header        = '0;
      x_byte        = '0;
      held_x        = '0;
      held_y        = '0;
      held_blue     = 1'b0;
      held_yellow   = 1'b0;
      held_red      = 1'b0;
      ticks         = '0;
      fail_count_o  = 0;
      items_o       = 0;
      reports_o     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_report();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_o++;
        decode_item(s_axis_tuser, s_axis_tdata[6:0]);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_ticks = cfg_data_i;
      end
    end
    pending_o <= expected_reports.size();
  end

endmodule

`default_nettype wire

// ===== verif/joystick_serial_record_decoder_test.sv =====
// Testbench top for the joystick serial record decoder: stimulus, idling and verdict.
`default_nettype none

module joystick_serial_record_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int items_seen;
  int reports_seen;
  int cycle_count   = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 52;
  int timeout_now   = int'(jsrd_pkg::TIMEOUT_RESET);
  int timeout_writes = 0;

  // Last record sent, reused to send the same record again
  logic [6:0] prev_hdr = 7'h40;
  logic [6:0] prev_x   = '0;
  logic [6:0] prev_y   = '0;

  joystick_serial_record_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  joystick_report_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .items_o       (items_seen),
    .reports_o     (reports_seen)
  );

  always #10 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count, pending);
      $display("joystick_serial_record_decoder_test failed");
      $finish;
    end
  end

  // One input transaction, after a random number of idle cycles
  task automatic send_item(input logic cmd, input logic [6:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, b};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_char(input logic [6:0] b);
    send_item(jsrd_pkg::CMD_BYTE, b);
  endtask

  task automatic send_tick();
    send_item(jsrd_pkg::CMD_TICK, 7'($urandom));
  endtask

  task automatic send_record(input logic [6:0] hdr, input logic [6:0] xb,
                             input logic [6:0] yb);
    send_char(hdr);
    send_char(xb);
    send_char(yb);
    prev_hdr = hdr;
    prev_x   = xb;
    prev_y   = yb;
  endtask

  // Stop sending and wait until every expected report is out
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_now = int'(value);
    timeout_writes++;
  endtask

  // Mostly well-formed records with random content, plus tick bursts and noise
  task automatic random_items(input int target);
    int         sent;
    int         pick;
    int         burst;
    int         v;
    logic [7:0] rx;
    logic [7:0] ry;
    logic [6:0] hdr;
    logic [6:0] xb;
    logic [6:0] yb;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // same record again: no change unless a timeout cleared the axes or noise broke the framing
        send_record(prev_hdr, prev_x, prev_y);
        sent += 3;
      end else if (pick < 55) begin
        if ($urandom_range(1) == 0) begin
          // small axes, mostly inside the clamp
          v  = int'($urandom_range(80)) - 40;
          rx = v[7:0];
          v  = int'($urandom_range(80)) - 40;
          ry = v[7:0];
          hdr = {1'b1, 2'($urandom), ry[7:6], rx[7:6]};
          xb  = {1'b0, rx[5:0]};
          yb  = {1'b0, ry[5:0]};
        end else begin
          hdr = {1'b1, 6'($urandom)};
          xb  = 7'($urandom);
          yb  = 7'($urandom);
        end
        send_char(hdr);
        if ($urandom_range(9) == 0) begin
          send_tick();
          sent++;
        end
        send_char(xb);
        send_char(yb);
        prev_hdr = hdr;
        prev_x   = xb;
        prev_y   = yb;
        sent += 3;
        if ($urandom_range(1) == 0) begin
          send_char(($urandom_range(3) == 0) ? 7'h00 : {1'b0, 6'($urandom)});
          sent++;
        end
      end else if (pick < 85) begin
        burst = (timeout_now < 20) ? timeout_now + 4 : 6;
        burst = $urandom_range(burst, 1);
        repeat (burst) send_tick();
        sent += burst;
      end else begin
        send_char(7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Greeting, even when it looks like a header
    send_char(7'h7F);
    send_char(7'h00);
    // No header yet: dropped
    send_char(7'h15);
    send_tick();
    // Blue and red on, both raw axes -1
    send_record(7'h7F, 7'h7F, 7'h7F);
    // Buttons off, X raw +127 and Y raw -128, both clamped
    send_record(7'h49, 7'h3F, 7'h00);
    // Trailing byte sets yellow
    send_char(7'h01);
    // Unchanged record, then a header where a trailing byte could go
    send_record(7'h49, 7'h3F, 7'h00);
    // X raw -128, Y raw +127, blue on
    send_record(7'h56, 7'h00, 7'h3F);
    // Zero trailing byte clears yellow
    send_char(7'h00);
    // Bit 6 set on the axis bytes is taken as data
    send_record(7'h40, 7'h7F, 7'h40);
    send_tick();
    // Header after record, tick in the middle of the next record
    send_char(7'h7F);
    send_char(7'h3F);
    send_tick();
    send_char(7'h2A);

    // Axes are nonzero: the reset timeout fires after 201 ticks
    send_record(7'h40, 7'h7F, 7'h40);
    repeat (205) send_tick();
    random_items(100);
    quiesce();

    write_timeout(24'd0);
    send_idle_pct = 52;
    recv_idle_pct = 22;
    random_items(100);
    quiesce();

    write_timeout(24'd7);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(90);
    quiesce();

    // Largest timeout: axes are never cleared by ticks
    write_timeout(24'hFF_FFFF);
    random_items(30);
    quiesce();

    $display("Covered %0d input transactions and %0d report transactions",
             items_seen, reports_seen);
    $display("over the reset timeout and %0d written timeouts, three idling mixes",
             timeout_writes);
    if (fail_count == 0) begin
      $display("joystick_serial_record_decoder_test passed");
    end else begin
      $display("joystick_serial_record_decoder_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/jsrd_pkg.sv
rtl/jsrd_decode.sv
rtl/jsrd_out_q.sv
rtl/joystick_serial_record_decoder.sv
verif/joystick_report_checker.sv
verif/joystick_serial_record_decoder_test.sv
